[rtl/weighted_peer_picker_with_failout_assert.svh]
`ifndef WEIGHTED_PEER_PICKER_WITH_FAILOUT_ASSERT_SVH
`define WEIGHTED_PEER_PICKER_WITH_FAILOUT_ASSERT_SVH

// same-cycle implication, checked on clk with reset masked
`define WPPF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define WPPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/wppf_pkg.sv]
package wppf_pkg;

	// sizes
	localparam int MAX_PEERS_DEF = 8;
	localparam int PEER_IDX_W    = 3;
	localparam int TIME_W        = 48;
	localparam int DOWN_W        = 49;
	localparam int RW_W          = 16;
	localparam int WEIGHT_W      = 8;
	localparam int TOTAL_W       = WEIGHT_W + PEER_IDX_W;
	localparam int LIMIT_W       = 4;
	localparam int WINDOW_W      = 16;
	localparam int COUNT_W       = 4;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;

	// register reset values
	localparam logic [COUNT_W-1:0] PEER_COUNT_RST   = 4'd1;
	localparam logic [63:0]        PEER_WEIGHTS_RST = 64'h0101_0101_0101_0101;
	localparam logic [31:0]        FAIL_LIMITS_RST  = 32'h1111_1111;
	localparam logic [63:0]        FAIL_WINDOWS_RST = 64'h2710_2710_2710_2710;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PEER_COUNT        = 3'd0,
		CFG_PEER_WEIGHTS      = 3'd1,
		CFG_FAIL_LIMITS       = 3'd2,
		CFG_FAIL_WINDOWS_LOW  = 3'd3,
		CFG_FAIL_WINDOWS_HIGH = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		CMD_PICK   = 1'b0,
		CMD_REPORT = 1'b1
	} cmd_t;

	typedef logic signed [RW_W-1:0] rw_t;
	typedef logic [WEIGHT_W-1:0]    weight_t;
	typedef logic [TOTAL_W-1:0]     total_t;

	typedef struct packed {
		logic                  found;
		logic [PEER_IDX_W-1:0] chosen_peer;
	} pick_res_t;

	// add a non-negative weight, clamp at the positive limit
	function automatic rw_t sat_add(input rw_t a, input weight_t w);
		logic [RW_W:0] s;
		s = {a[RW_W-1], a} + {{(RW_W+1-WEIGHT_W){1'b0}}, w};
		if (s[RW_W] != s[RW_W-1])
			return {1'b0, {(RW_W-1){1'b1}}};
		return rw_t'(s[RW_W-1:0]);
	endfunction

	// subtract the pass total, clamp at the negative limit
	function automatic rw_t sat_sub(input rw_t a, input total_t t);
		logic [RW_W+1:0] d;
		d = {{2{a[RW_W-1]}}, a} - {{(RW_W+2-TOTAL_W){1'b0}}, t};
		if (d[RW_W+1:RW_W-1] == 3'b000 || d[RW_W+1:RW_W-1] == 3'b111)
			return rw_t'(d[RW_W-1:0]);
		return {1'b1, {(RW_W-1){1'b0}}};
	endfunction

endpackage

[rtl/wppf_req_if.sv]
interface wppf_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  tried_mask;
	logic [2:0]  peer_index;
	logic        success;
	logic [47:0] now_ms;

	modport source(output valid, cmd, tried_mask, peer_index, success, now_ms, input ready);
	modport sink(input valid, cmd, tried_mask, peer_index, success, now_ms, output ready);
endinterface

[rtl/wppf_rsp_if.sv]
interface wppf_rsp_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [2:0] chosen_peer;

	modport source(output valid, found, chosen_peer, input ready);
	modport sink(input valid, found, chosen_peer, output ready);
endinterface

[rtl/wppf_swrr_core.sv]
module wppf_swrr_core #(
	parameter int MAX_PEERS = wppf_pkg::MAX_PEERS_DEF
) (
	input  logic [MAX_PEERS-1:0] elig,
	input  wppf_pkg::weight_t    weight  [MAX_PEERS],
	input  wppf_pkg::rw_t        rw      [MAX_PEERS],
	output wppf_pkg::rw_t        rw_next [MAX_PEERS],
	output wppf_pkg::pick_res_t  res
);
	import wppf_pkg::*;

	rw_t    added [MAX_PEERS];
	total_t total;

	// eligible peers gain their weight, the pass total is summed
	always_comb begin
		total = '0;
		for (int i = 0; i < MAX_PEERS; i++) begin
			added[i] = elig[i] ? sat_add(rw[i], weight[i]) : rw[i];
			if (elig[i])
				total = total + {{(TOTAL_W-WEIGHT_W){1'b0}}, weight[i]};
		end
	end

	// highest running weight wins, lowest index on ties
	always_comb begin
		rw_t best_val;
		best_val = '0;
		res = '0;
		for (int i = 0; i < MAX_PEERS; i++) begin
			if (elig[i] && (!res.found || added[i] > best_val)) begin
				res.found = 1'b1;
				res.chosen_peer = PEER_IDX_W'(i);
				best_val = added[i];
			end
		end
	end

	// winner pays back the pass total
	always_comb begin
		for (int i = 0; i < MAX_PEERS; i++) begin
			if (res.found && res.chosen_peer == PEER_IDX_W'(i))
				rw_next[i] = sat_sub(added[i], total);
			else
				rw_next[i] = added[i];
		end
	end

endmodule

[rtl/weighted_peer_picker_with_failout.sv]
// path: a taken transaction passes the input stage, then the result register
// throughput: one transaction per cycle unless rsp stalls, set by the single
//   input stage; its pick or report logic updates peer state in the same cycle
// reset: arst_n clears running weights, fail counts and down marks, loads the
//   default register values and empties both stages
module weighted_peer_picker_with_failout #(
	parameter int MAX_PEERS = wppf_pkg::MAX_PEERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	wppf_req_if.sink                         req,
	wppf_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [wppf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wppf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wppf_pkg::*;

	`include "weighted_peer_picker_with_failout_assert.svh"

	// configuration registers
	logic [COUNT_W-1:0] peer_count_q;
	logic [63:0]        peer_weights_q;
	logic [31:0]        fail_limits_q;
	logic [63:0]        fail_windows_low_q;
	logic [63:0]        fail_windows_high_q;

	// input stage
	logic                  valid_s1;
	logic                  cmd_s1;
	logic [7:0]            tried_mask_s1;
	logic [PEER_IDX_W-1:0] peer_index_s1;
	logic                  success_s1;
	logic [TIME_W-1:0]     now_ms_s1;

	// result register
	logic                  out_valid_q;
	logic                  found_q;
	logic [PEER_IDX_W-1:0] chosen_peer_q;

	// peer state
	rw_t                rw_q    [MAX_PEERS];
	logic [COUNT_W-1:0] fc_q    [MAX_PEERS];
	logic [TIME_W-1:0]  ws_q    [MAX_PEERS];
	logic [DOWN_W-1:0]  du_q    [MAX_PEERS];

	logic                  adv;
	logic                  fire;
	logic                  pick_fire;
	logic [COUNT_W-1:0]    n_eff;
	logic [MAX_PEERS-1:0]  in_use;
	logic [MAX_PEERS-1:0]  is_down;
	logic [MAX_PEERS-1:0]  elig_any;
	logic [MAX_PEERS-1:0]  elig_up;
	logic [MAX_PEERS-1:0]  elig;
	logic [127:0]          windows;
	weight_t               weight  [MAX_PEERS];
	rw_t                   rw_next [MAX_PEERS];
	pick_res_t             pick_res;

	// handshake
	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	assign fire      = valid_s1 && adv;
	assign pick_fire = fire && cmd_s1 == CMD_PICK;

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.chosen_peer = chosen_peer_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_count_q        <= PEER_COUNT_RST;
			peer_weights_q      <= PEER_WEIGHTS_RST;
			fail_limits_q       <= FAIL_LIMITS_RST;
			fail_windows_low_q  <= FAIL_WINDOWS_RST;
			fail_windows_high_q <= FAIL_WINDOWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PEER_COUNT:        peer_count_q        <= cfg_data[COUNT_W-1:0];
				CFG_PEER_WEIGHTS:      peer_weights_q      <= cfg_data;
				CFG_FAIL_LIMITS:       fail_limits_q       <= cfg_data[31:0];
				CFG_FAIL_WINDOWS_LOW:  fail_windows_low_q  <= cfg_data;
				CFG_FAIL_WINDOWS_HIGH: fail_windows_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1        <= req.cmd;
			tried_mask_s1 <= req.tried_mask;
			peer_index_s1 <= req.peer_index;
			success_s1    <= req.success;
			now_ms_s1     <= req.now_ms;
		end
	end

	// peers in use and eligibility for both passes
	assign n_eff   = (peer_count_q > COUNT_W'(MAX_PEERS)) ? COUNT_W'(MAX_PEERS) : peer_count_q;
	assign windows = {fail_windows_high_q, fail_windows_low_q};

	always_comb begin
		for (int i = 0; i < MAX_PEERS; i++) begin
			in_use[i]  = COUNT_W'(i) < n_eff;
			is_down[i] = du_q[i] > {1'b0, now_ms_s1};
			weight[i]  = peer_weights_q[WEIGHT_W*i +: WEIGHT_W];
		end
		elig_any = in_use & ~tried_mask_s1[MAX_PEERS-1:0];
		elig_up  = elig_any & ~is_down;
		elig     = (|elig_up) ? elig_up : elig_any;
	end

	wppf_swrr_core #(
		.MAX_PEERS(MAX_PEERS)
	) u_core (
		.elig    (elig),
		.weight  (weight),
		.rw      (rw_q),
		.rw_next (rw_next),
		.res     (pick_res)
	);

	// per-peer state: running weight and failure tracking
	for (genvar g = 0; g < MAX_PEERS; g++) begin : g_peer
		logic [LIMIT_W-1:0]  limit;
		logic [WINDOW_W-1:0] window;
		logic [TIME_W-1:0]   age;
		logic                hit;
		logic                restart;
		logic [COUNT_W-1:0]  fc_inc;
		logic                trip;

		assign limit   = fail_limits_q[LIMIT_W*g +: LIMIT_W];
		assign window  = windows[WINDOW_W*g +: WINDOW_W];
		assign hit     = fire && cmd_s1 == CMD_REPORT && in_use[g]
			&& peer_index_s1 == PEER_IDX_W'(g);
		assign age     = now_ms_s1 - ws_q[g];
		assign restart = fc_q[g] == '0 || (now_ms_s1 >= ws_q[g]
			&& age > {{(TIME_W-WINDOW_W){1'b0}}, window});
		assign fc_inc  = (restart ? '0 : fc_q[g]) + COUNT_W'(1);
		assign trip    = fc_inc >= limit;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rw_q[g] <= '0;
				fc_q[g] <= '0;
				ws_q[g] <= '0;
				du_q[g] <= '0;
			end else begin
				if (pick_fire)
					rw_q[g] <= rw_next[g];
				if (hit && success_s1) begin
					fc_q[g] <= '0;
				end else if (hit && limit != '0) begin
					if (restart)
						ws_q[g] <= now_ms_s1;
					fc_q[g] <= trip ? '0 : fc_inc;
					if (trip)
						du_q[g] <= {1'b0, now_ms_s1}
							+ {{(DOWN_W-WINDOW_W){1'b0}}, window};
				end
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= valid_s1;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			found_q       <= (cmd_s1 == CMD_PICK) && pick_res.found;
			chosen_peer_q <= (cmd_s1 == CMD_PICK && pick_res.found)
				? pick_res.chosen_peer : '0;
		end
	end

	// checks
	`WPPF_ASSERT_IMPL(a_pick_not_tried, valid_s1 && cmd_s1 == CMD_PICK && pick_res.found, !tried_mask_s1[pick_res.chosen_peer], "chosen peer was already tried")
	`WPPF_ASSERT_IMPL(a_pick_in_use, valid_s1 && cmd_s1 == CMD_PICK && pick_res.found, {1'b0, pick_res.chosen_peer} < n_eff, "chosen peer not in use")
	`WPPF_ASSERT_NEXT(a_fire_gives_result, fire, rsp.valid, "transaction left the input stage without a result")
	`WPPF_ASSERT_NEXT(a_report_not_found, fire && cmd_s1 == CMD_REPORT, !rsp.found && rsp.chosen_peer == '0, "report transaction returned a peer")

endmodule
